// File: src/hpfma_pkg.sv
package hpfma_pkg;

  typedef struct packed {
    logic [15:0] mul_a;
    logic [15:0] mul_b;
    logic [15:0] addend;
  } in_req_t;

  typedef struct packed {
    logic [15:0] result;
    logic        flag_inexact;
    logic        flag_overflow;
    logic        flag_underflow;
  } out_req_t;

  typedef enum logic [1:0] {
    RM_NEAREST = 2'd0,
    RM_ZERO    = 2'd1,
    RM_UP      = 2'd2,
    RM_DOWN    = 2'd3
  } rmode_t;

  localparam logic [15:0] INF_BITS   = 16'h7C00;
  localparam logic [15:0] NAN_BITS   = 16'h7C01;
  localparam logic [15:0] FRAC_MASK  = 16'h03FF;
  localparam logic [15:0] SIGN_BIT   = 16'h8000;
  localparam logic [15:0] MAG_MASK   = 16'h7FFF;
  localparam logic [15:0] MAX_FINITE = 16'h7BFF;
  localparam int          EXP_BIAS   = 15;

  // Aligned sum: fixed point with weight 2^-49 at bit 0, one bit below the lowest product bit.
  localparam int SUM_W = 82;

  // Stage 1 to stage 2: aligned signed operands and special-case decisions.
  typedef struct packed {
    logic              special;
    logic [15:0]       special_res;
    logic              sign_p;
    logic              sign_c;
    logic [SUM_W-1:0]  mag_p;
    logic [SUM_W-1:0]  mag_c;
    logic [1:0]        rm;
  } st1_t;

  // Stage 2 to stage 3: signed-magnitude sum.
  typedef struct packed {
    logic              special;
    logic [15:0]       special_res;
    logic              sign;
    logic [SUM_W-1:0]  mag;
    logic [1:0]        rm;
  } st2_t;

  // Stage 3 to stage 4: normalised significand with leading one at the top.
  typedef struct packed {
    logic              special;
    logic [15:0]       special_res;
    logic              sign;
    logic              zero;
    logic [SUM_W-1:0]  norm;
    logic signed [8:0] e;
    logic [1:0]        rm;
  } st3_t;

endpackage

// File: src/hpfma_align.sv
module hpfma_align (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  hpfma_pkg::in_req_t in_data,
  input  logic [1:0]        rm,
  output logic              st_valid_r,
  output hpfma_pkg::st1_t   st_r
);
  import hpfma_pkg::*;

  logic [4:0]  ea, eb, ec;
  logic [9:0]  fa, fb, fc;
  logic        sp, sc, inf_p, zero_p, zero_c, nan_in;
  logic [10:0] ma, mb, mc;
  logic [21:0] mp;
  logic [6:0]  shp, shc;
  st1_t        st_nxt;

  always_comb begin
    ea = in_data.mul_a[14:10];
    eb = in_data.mul_b[14:10];
    ec = in_data.addend[14:10];
    fa = in_data.mul_a[9:0];
    fb = in_data.mul_b[9:0];
    fc = in_data.addend[9:0];
    sp = in_data.mul_a[15] ^ in_data.mul_b[15];
    sc = in_data.addend[15];
    inf_p  = (ea == 5'd31) || (eb == 5'd31);
    zero_p = ((in_data.mul_a & MAG_MASK) == 16'd0) || ((in_data.mul_b & MAG_MASK) == 16'd0);
    zero_c = (in_data.addend & MAG_MASK) == 16'd0;
    nan_in = (ea == 5'd31 && fa != 10'd0) || (eb == 5'd31 && fb != 10'd0) ||
             (ec == 5'd31 && fc != 10'd0);
    ma = {(ea != 5'd0), fa};
    mb = {(eb != 5'd0), fb};
    mc = {(ec != 5'd0), fc};
    mp = ma * mb;
    // Product lsb weight is 2^(ea'+eb'-50); bit 0 of the sum is 2^-49, one bit below the lowest product bit.
    shp = 7'((ea == 5'd0 ? 5'd1 : ea)) + 7'((eb == 5'd0 ? 5'd1 : eb)) - 7'd1;
    shc = 7'((ec == 5'd0 ? 5'd1 : ec)) + 7'd24;
    st_nxt.rm          = rm;
    st_nxt.sign_p      = sp;
    st_nxt.sign_c      = sc;
    st_nxt.mag_p       = SUM_W'(mp) << shp;
    st_nxt.mag_c       = zero_c ? '0 : (SUM_W'(mc) << shc);
    st_nxt.special     = 1'b1;
    st_nxt.special_res = NAN_BITS;
    if (nan_in) begin
      st_nxt.special_res = NAN_BITS;
    end else if (inf_p) begin
      if (zero_p || (ec == 5'd31 && sc != sp)) begin
        st_nxt.special_res = NAN_BITS;
      end else begin
        st_nxt.special_res = {sp, 15'h7C00};
      end
    end else if (ec == 5'd31) begin
      st_nxt.special_res = in_data.addend;
    end else if (zero_p) begin
      if (zero_c) begin
        st_nxt.special_res = {(sp == sc) ? sp : (rm == RM_DOWN), 15'd0};
      end else begin
        st_nxt.special_res = in_data.addend;
      end
    end else begin
      st_nxt.special = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_valid_r <= 1'b0;
    end else begin
      st_valid_r <= in_valid;
    end
    st_r <= st_nxt;
  end

endmodule

// File: src/hpfma_add.sv
module hpfma_add (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            st_valid,
  input  hpfma_pkg::st1_t st_in,
  output logic            add_valid_r,
  output hpfma_pkg::st2_t add_r,
  output logic            norm_valid_r,
  output hpfma_pkg::st3_t norm_r
);
  import hpfma_pkg::*;

  st2_t       add_nxt;
  st3_t       norm_nxt;
  logic [6:0] lz;

  always_comb begin
    add_nxt.special     = st_in.special;
    add_nxt.special_res = st_in.special_res;
    add_nxt.rm          = st_in.rm;
    if (st_in.sign_p == st_in.sign_c) begin
      add_nxt.mag  = st_in.mag_p + st_in.mag_c;
      add_nxt.sign = st_in.sign_p;
    end else if (st_in.mag_p >= st_in.mag_c) begin
      add_nxt.mag  = st_in.mag_p - st_in.mag_c;
      add_nxt.sign = st_in.sign_p;
    end else begin
      add_nxt.mag  = st_in.mag_c - st_in.mag_p;
      add_nxt.sign = st_in.sign_c;
    end
  end

  always_comb begin
    lz = 7'd0;
    for (int i = 0; i < SUM_W; i++) begin
      if (add_r.mag[i]) begin
        lz = 7'(SUM_W - 1 - i);
      end
    end
    norm_nxt.special     = add_r.special;
    norm_nxt.special_res = add_r.special_res;
    norm_nxt.sign        = add_r.sign;
    norm_nxt.rm          = add_r.rm;
    norm_nxt.zero        = add_r.mag == '0;
    norm_nxt.norm        = add_r.mag << lz;
    // Value of the leading one is 2^(SUM_W-1-lz-49).
    norm_nxt.e           = 9'(SUM_W - 50) - 9'(lz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_valid_r  <= 1'b0;
      norm_valid_r <= 1'b0;
    end else begin
      add_valid_r  <= st_valid;
      norm_valid_r <= add_valid_r;
    end
    add_r  <= add_nxt;
    norm_r <= norm_nxt;
  end

endmodule

// File: src/hpfma_round.sv
module hpfma_round (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 norm_valid,
  input  hpfma_pkg::st3_t      norm_in,
  output logic                 out_strobe_r,
  output hpfma_pkg::out_req_t  out_r
);
  import hpfma_pkg::*;

  out_req_t    out_nxt;
  logic [4:0]  dsh;
  logic [SUM_W-1:0] den;
  logic [10:0] kept;
  logic [11:0] kinc;
  logic        g, st, inexact, inc, to_inf;
  logic signed [9:0] q;
  logic signed [9:0] field;

  always_comb begin
    // Results below 2^-14 keep fewer bits: shift right, folding lost bits into sticky.
    if (norm_in.e < -9'sd14) begin
      dsh = (norm_in.e < -9'sd26) ? 5'd12 : 5'(-9'sd14 - norm_in.e);
    end else begin
      dsh = 5'd0;
    end
    den  = norm_in.norm >> dsh;
    kept = den[SUM_W-1 -: 11];
    g    = den[SUM_W-12];
    st   = (den[SUM_W-13:0] != '0) || ((norm_in.norm & ~(den << dsh)) != '0);
    inexact = g | st;
    q = (norm_in.e < -9'sd14) ? -10'sd24 : 10'(norm_in.e) - 10'sd10;
    case (norm_in.rm)
      RM_NEAREST: inc = g & (st | kept[0]);
      RM_UP:      inc = inexact & ~norm_in.sign;
      RM_DOWN:    inc = inexact & norm_in.sign;
      default:    inc = 1'b0;
    endcase
    kinc = {1'b0, kept} + 12'(inc);
    if (kinc[11]) begin
      kinc = kinc >> 1;
      q = q + 10'sd1;
    end
    field = q + 10'sd25;
    to_inf = (norm_in.rm == RM_NEAREST) || (norm_in.rm == RM_UP && !norm_in.sign) ||
             (norm_in.rm == RM_DOWN && norm_in.sign);
    out_nxt = '0;
    if (norm_in.special) begin
      out_nxt.result = norm_in.special_res;
    end else if (norm_in.zero) begin
      out_nxt.result = {(norm_in.rm == RM_DOWN), 15'd0};
    end else if (kinc[10] && field >= 10'sd31) begin
      out_nxt.result = {norm_in.sign, to_inf ? INF_BITS[14:0] : MAX_FINITE[14:0]};
      out_nxt.flag_inexact  = 1'b1;
      out_nxt.flag_overflow = 1'b1;
    end else begin
      if (!kinc[10]) begin
        out_nxt.result = {norm_in.sign, 5'd0, kinc[9:0]};
      end else begin
        out_nxt.result = {norm_in.sign, field[4:0], kinc[9:0]};
      end
      out_nxt.flag_inexact   = inexact;
      out_nxt.flag_underflow = inexact && (norm_in.e < -9'sd14);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= norm_valid;
    end
    out_r <= out_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_r.flag_overflow |-> out_r.flag_inexact)
    else $error("overflow without inexact");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_r.flag_underflow |-> out_r.flag_inexact)
    else $error("underflow without inexact");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_r.flag_overflow |-> !out_r.flag_underflow)
    else $error("overflow and underflow together");

endmodule

// File: src/half_precision_fused_multiply_add.sv
// Binary16 fused multiply-add: result = round(mul_a * mul_b + addend) with a single
// rounding in the mode held in the configuration register (write it only while idle).
// A request is taken on any cycle start is high; busy is never raised. Each result
// appears for one cycle with out_strobe, carrying inexact, overflow and underflow
// flags. The four register stages are operand alignment, wide add, normalisation
// and rounding. The receiver cannot stall, so nothing is held back.
module half_precision_fused_multiply_add (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  hpfma_pkg::in_req_t   in_req,
  output logic                 out_strobe,
  output hpfma_pkg::out_req_t  out_req,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_rounding_mode
);
  import hpfma_pkg::*;

  logic [1:0] rm_r;
  logic       s1_valid, s2_valid, s3_valid;
  st1_t       s1;
  st2_t       s2;
  st3_t       s3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rm_r <= RM_NEAREST;
    end else if (cfg_we) begin
      rm_r <= cfg_rounding_mode;
    end
  end

  assign busy = 1'b0;

  hpfma_align u_align (
    .clk, .rst_n, .in_valid(start), .in_data(in_req), .rm(rm_r),
    .st_valid_r(s1_valid), .st_r(s1)
  );

  hpfma_add u_add (
    .clk, .rst_n, .st_valid(s1_valid), .st_in(s1),
    .add_valid_r(s2_valid), .add_r(s2), .norm_valid_r(s3_valid), .norm_r(s3)
  );

  hpfma_round u_round (
    .clk, .rst_n, .norm_valid(s3_valid), .norm_in(s3),
    .out_strobe_r(out_strobe), .out_r(out_req)
  );

  assert property (@(posedge clk) disable iff (!rst_n)
    start |-> ##4 out_strobe)
    else $error("request lost in pipeline");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(s1_valid, 3))
    else $error("result without request");

  assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid |-> $past(s1_valid))
    else $error("valid bit mismatch");

endmodule
